>>> hw/rtl/lphs_pkg.sv
// Shared types and constants of the linear-probe hash set.
package lphs_pkg;

	localparam int TABLE_SIZE = 64;
	localparam int KEY_WIDTH  = 16;
	localparam int SLOT_W     = $clog2(TABLE_SIZE);
	localparam int CNT_W      = $clog2(TABLE_SIZE + 1);

	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_LOOKUP = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS,
		ST_LK_ADDR,
		ST_LK_CMP,
		ST_RESP
	} state_t;

	// key store access
	typedef struct packed {
		logic                 we;
		logic [SLOT_W-1:0]    addr;
		logic [KEY_WIDTH-1:0] wdata;
	} mem_req_t;

	// occupancy bit access
	typedef struct packed {
		logic              set;
		logic              clear_all;
		logic [SLOT_W-1:0] idx;
	} used_req_t;

	// result handed to the output register
	typedef struct packed {
		logic load;
		logic found;
		logic status;
	} res_t;

endpackage

>>> hw/rtl/lphs_key_mem.sv
// Key store: one address port, write and registered read each cycle.
module lphs_key_mem (
	input  logic                           clk,
	input  lphs_pkg::mem_req_t             req,
	output logic [lphs_pkg::KEY_WIDTH-1:0] rdata
);

	logic [lphs_pkg::KEY_WIDTH-1:0] mem [lphs_pkg::TABLE_SIZE];
	logic [lphs_pkg::KEY_WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		rdata_q <= mem[req.addr];
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/lphs_used_bits.sv
// Per-slot occupancy flags, all cleared together by one clear request.
module lphs_used_bits (
	input  logic                clk,
	input  logic                arst_n,
	input  lphs_pkg::used_req_t req,
	output logic                used
);

	logic [lphs_pkg::TABLE_SIZE-1:0] used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (req.clear_all) begin
			used_q <= '0;
		end else if (req.set) begin
			used_q[req.idx] <= 1'b1;
		end
	end

	assign used = used_q[req.idx];

endmodule

>>> hw/rtl/lphs_probe_ctrl.sv
// Probe sequencer: walks slots one step at a time for insert and lookup.
module lphs_probe_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     kind,
	input  logic [15:0]                    key,
	input  logic                           out_free,
	input  logic                           used,
	input  logic [lphs_pkg::KEY_WIDTH-1:0] rdata,
	output lphs_pkg::mem_req_t             mem_req,
	output lphs_pkg::used_req_t            used_req,
	output lphs_pkg::res_t                 res
);

	lphs_pkg::state_t                 state_q, state_d;
	logic [lphs_pkg::SLOT_W-1:0]      slot_q, slot_d, slot_nxt;
	logic [lphs_pkg::CNT_W-1:0]       cnt_q, cnt_d;
	logic [lphs_pkg::KEY_WIDTH-1:0]   key_q, key_d;
	logic                             found_q, found_d;
	logic                             status_q, status_d;
	logic                             all_probed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lphs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		slot_q   <= slot_d;
		cnt_q    <= cnt_d;
		key_q    <= key_d;
		found_q  <= found_d;
		status_q <= status_d;
	end

	assign slot_nxt = (slot_q == lphs_pkg::SLOT_W'(lphs_pkg::TABLE_SIZE - 1)) ?
		'0 : slot_q + 1'b1;
	assign all_probed = (cnt_q == lphs_pkg::CNT_W'(lphs_pkg::TABLE_SIZE));

	always_comb begin
		state_d  = state_q;
		slot_d   = slot_q;
		cnt_d    = cnt_q;
		key_d    = key_q;
		found_d  = found_q;
		status_d = status_q;
		in_stall = 1'b1;
		mem_req  = '{we: 1'b0, addr: slot_q, wdata: key_q};
		used_req = '{set: 1'b0, clear_all: 1'b0, idx: slot_q};
		res      = '{load: 1'b0, found: found_q, status: status_q};

		case (state_q)
			lphs_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					key_d    = key[lphs_pkg::KEY_WIDTH-1:0];
					// home slot: key modulo table size
					slot_d   = lphs_pkg::SLOT_W'(key_d % lphs_pkg::TABLE_SIZE);
					cnt_d    = '0;
					found_d  = 1'b0;
					status_d = 1'b0;
					case (kind)
						lphs_pkg::KIND_CLEAR: begin
							used_req.clear_all = 1'b1;
							state_d = lphs_pkg::ST_RESP;
						end
						lphs_pkg::KIND_INSERT: state_d = lphs_pkg::ST_INS;
						lphs_pkg::KIND_LOOKUP: state_d = lphs_pkg::ST_LK_ADDR;
						default:               state_d = lphs_pkg::ST_RESP;
					endcase
				end
			end
			lphs_pkg::ST_INS: begin
				if (all_probed) begin
					status_d = 1'b1;
					state_d  = lphs_pkg::ST_RESP;
				end else if (!used) begin
					mem_req.we   = 1'b1;
					used_req.set = 1'b1;
					state_d      = lphs_pkg::ST_RESP;
				end else begin
					slot_d = slot_nxt;
					cnt_d  = cnt_q + 1'b1;
				end
			end
			lphs_pkg::ST_LK_ADDR: begin
				// key read issued at slot_q every cycle
				if (all_probed || !used) begin
					state_d = lphs_pkg::ST_RESP;
				end else begin
					state_d = lphs_pkg::ST_LK_CMP;
				end
			end
			lphs_pkg::ST_LK_CMP: begin
				if (rdata == key_q) begin
					found_d = 1'b1;
					state_d = lphs_pkg::ST_RESP;
				end else begin
					slot_d  = slot_nxt;
					cnt_d   = cnt_q + 1'b1;
					state_d = lphs_pkg::ST_LK_ADDR;
				end
			end
			lphs_pkg::ST_RESP: begin
				if (out_free) begin
					res.load = 1'b1;
					state_d  = lphs_pkg::ST_IDLE;
				end
			end
			default: state_d = lphs_pkg::ST_IDLE;
		endcase
	end

endmodule

>>> hw/rtl/linear_probe_hash_set_top.sv
// Top level of the linear-probe hash set: sequencer, stores and output register.
//
// Hash set of 64 slots holding 16-bit keys, open addressing with linear
// probing from home slot key mod 64, wrapping at the end of the table. One
// item is taken at a time; in_stall is high from the cycle after acceptance
// until its result has been moved into the output register. Clear and the
// unused kind go straight to the result. An insert steps over occupied
// slots, one occupancy check per cycle, and writes the first empty one. A
// lookup checks the occupancy of a slot while reading its key, then
// compares the key, and stops when it hits, at an empty slot or after all
// slots; the compare waits because the single key memory port returns
// registered read data in the cycle after the address. An insert into a full
// table reports status 1; a lookup that misses in a full table gives up
// after all 64 slots. Occupancy flags are flip-flops cleared by reset and
// by clear, so no clearing pass is needed after reset. The result register
// lets the next item be accepted while a result still waits on out_stall.
module linear_probe_hash_set_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [15:0] key,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic        status
);

	lphs_pkg::mem_req_t             mem_req;
	lphs_pkg::used_req_t            used_req;
	lphs_pkg::res_t                 res;
	logic [lphs_pkg::KEY_WIDTH-1:0] rdata;
	logic                           used;
	logic                           out_free;
	logic                           out_valid_q;
	logic                           found_q;
	logic                           status_q;

	// output slot can take a new item when empty or being drained
	assign out_free = !out_valid_q || !out_stall;

	lphs_probe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.key      (key),
		.out_free (out_free),
		.used     (used),
		.rdata    (rdata),
		.mem_req  (mem_req),
		.used_req (used_req),
		.res      (res)
	);

	lphs_key_mem u_key_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	lphs_used_bits u_used (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (used_req),
		.used   (used)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) begin
			found_q  <= res.found;
			status_q <= res.status;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign status    = status_q;

	// an accepted item keeps the block busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted twice in a row");

	// an insert only ever claims a slot that was empty
	a_insert_empty_slot: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |-> used_req.set && !used)
		else $error("insert overwrote an occupied slot");

	// a dropped insert never reports a hit
	a_status_found_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(found && status))
		else $error("found and status both set");

	// a result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res.load |-> out_free)
		else $error("result loaded over a pending result");

endmodule

>>> test/linear_probe_hash_set_top_tb.sv
// Self-checking testbench for the linear-probe hash set: opening table, then random episodes.
`timescale 1ns / 100ps

module linear_probe_hash_set_top_tb;
	import lphs_pkg::*;

	// kind code the block must ignore (no state change, zero result)
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int TARGET_ITEMS = 1650;
	// slowest item: full-table lookup miss plus the longest gap and stall on each side;
	// the limit is several times that for every item over the whole run
	localparam int CYCLE_LIMIT = 2_000_000;
	// longest single operation, waited out at the end
	localparam int DRAIN_CYCLES = 2 * TABLE_SIZE + 12;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [1:0]           kind;
	logic [KEY_WIDTH-1:0] key;
	logic                 out_valid;
	logic                 out_stall;
	logic                 found;
	logic                 status;

	linear_probe_hash_set_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.key      (key),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.found    (found),
		.status   (status)
	);

	// one opening item; typed = 1 means the answer is written in the row
	typedef struct packed {
		logic [1:0]           op;
		logic [KEY_WIDTH-1:0] k;
		logic                 typed;
		logic                 fnd;
		logic                 st;
	} step_t;

	// what the output side should hand back, oldest first
	typedef struct packed {
		logic [1:0]           op;
		logic [KEY_WIDTH-1:0] k;
		logic                 fnd;
		logic                 st;
	} answer_t;

	// Opening table. Key 16'hFFFF and 16'h003F both live in slot 63, so the second
	// one wraps round to the front of the table, which already holds key 0.
	step_t opening_ops [19] = '{
		'{KIND_LOOKUP, 16'h0000, 1'b1, 1'b0, 1'b0},	// empty table after reset
		'{KIND_LOOKUP, 16'hFFFF, 1'b1, 1'b0, 1'b0},
		'{KIND_INSERT, 16'h0000, 1'b1, 1'b0, 1'b0},	// smallest key
		'{KIND_INSERT, 16'hFFFF, 1'b1, 1'b0, 1'b0},	// largest key, last slot
		'{KIND_LOOKUP, 16'h0000, 1'b0, 1'b0, 1'b0},
		'{KIND_LOOKUP, 16'hFFFF, 1'b0, 1'b0, 1'b0},
		'{KIND_INSERT, 16'h003F, 1'b0, 1'b0, 1'b0},	// collides, wraps past slot 63
		'{KIND_LOOKUP, 16'h003F, 1'b0, 1'b0, 1'b0},	// probe must wrap as well
		'{KIND_INSERT, 16'h0000, 1'b0, 1'b0, 1'b0},	// duplicate goes into a new slot
		'{KIND_LOOKUP, 16'h0040, 1'b0, 1'b0, 1'b0},	// same home, not present
		'{KIND_LOOKUP, 16'h7FC0, 1'b0, 1'b0, 1'b0},
		'{KIND_UNUSED, 16'hAAAA, 1'b1, 1'b0, 1'b0},	// ignored kind
		'{KIND_UNUSED, 16'h5555, 1'b1, 1'b0, 1'b0},
		'{KIND_CLEAR,  16'hFFFF, 1'b1, 1'b0, 1'b0},	// key ignored on clear
		'{KIND_LOOKUP, 16'h0000, 1'b1, 1'b0, 1'b0},	// gone after clear
		'{KIND_LOOKUP, 16'h003F, 1'b1, 1'b0, 1'b0},
		'{KIND_INSERT, 16'h8000, 1'b0, 1'b0, 1'b0},
		'{KIND_LOOKUP, 16'h8000, 1'b0, 1'b0, 1'b0},
		'{KIND_CLEAR,  16'h0000, 1'b1, 1'b0, 1'b0}
	};

	// shadow copy of the table
	logic [KEY_WIDTH-1:0] shadow_keys [TABLE_SIZE];
	logic                 shadow_used [TABLE_SIZE];

	answer_t pending_answers [$];
	int      mismatches  = 0;
	int      items_sent  = 0;
	int      cycle_count = 0;
	bit      rush        = 1'b0;	// no gaps and no stalls while set

	// ---------------------------------------------------------------- shadow table

	function automatic logic shadow_insert(input logic [KEY_WIDTH-1:0] k);
		int slot;
		slot = int'(k) % TABLE_SIZE;
		for (int n = 0; n < TABLE_SIZE; n++) begin
			if (!shadow_used[slot]) begin
				shadow_keys[slot] = k;
				shadow_used[slot] = 1'b1;
				return 1'b0;
			end
			slot = (slot == TABLE_SIZE - 1) ? 0 : slot + 1;
		end
		return 1'b1;	// table full: key dropped
	endfunction

	function automatic logic shadow_lookup(input logic [KEY_WIDTH-1:0] k);
		int slot;
		slot = int'(k) % TABLE_SIZE;
		for (int n = 0; n < TABLE_SIZE; n++) begin
			if (!shadow_used[slot])
				return 1'b0;
			if (shadow_keys[slot] == k)
				return 1'b1;
			slot = (slot == TABLE_SIZE - 1) ? 0 : slot + 1;
		end
		return 1'b0;	// every slot visited
	endfunction

	// apply one operation to the shadow table and give the block's answer
	function automatic void shadow_apply(input logic [1:0] op, input logic [KEY_WIDTH-1:0] k,
			output logic fnd, output logic st);
		fnd = 1'b0;
		st  = 1'b0;
		case (op)
			KIND_CLEAR: begin
				for (int i = 0; i < TABLE_SIZE; i++)
					shadow_used[i] = 1'b0;
			end
			KIND_INSERT: st = shadow_insert(k);
			KIND_LOOKUP: fnd = shadow_lookup(k);
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------- random helpers

	// idle length: mostly none, some short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// keys biased towards collisions and towards the wrap at the end of the table
	function automatic logic [KEY_WIDTH-1:0] rand_key();
		logic [31:0] raw;
		raw = $urandom;
		case ($urandom_range(0, 3))
			0: return raw[KEY_WIDTH-1:0];
			1: return {raw[KEY_WIDTH-1:SLOT_W], 6'(60 + $urandom_range(0, 3))};
			2: return KEY_WIDTH'($urandom_range(0, 127));
			default: return {raw[KEY_WIDTH-1:SLOT_W], 6'($urandom_range(0, 3))};
		endcase
	endfunction

	// a key that is in the table now, or a random one if the table is empty
	function automatic logic [KEY_WIDTH-1:0] present_key();
		int start;
		int slot;
		start = $urandom_range(0, TABLE_SIZE - 1);
		for (int n = 0; n < TABLE_SIZE; n++) begin
			slot = (start + n) % TABLE_SIZE;
			if (shadow_used[slot])
				return shadow_keys[slot];
		end
		return rand_key();
	endfunction

	// ---------------------------------------------------------------- clock and reset

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d answers outstanding",
				cycle_count, pending_answers.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- input side

	// Present one item from a falling edge, hold it until it is taken, then work
	// out its answer. Returns at the falling edge after acceptance.
	task automatic send_op(input logic [1:0] op, input logic [KEY_WIDTH-1:0] k,
			input logic typed, input logic want_fnd, input logic want_st);
		int          gap;
		logic        fnd;
		logic        st;
		answer_t     ans;
		logic [31:0] noise;
		gap = rush ? 0 : idle_len();
		if (gap > 0) begin
			noise    = $urandom;
			in_valid = 1'b0;
			kind     = noise[17:16];	// junk payload while nothing is offered
			key      = noise[KEY_WIDTH-1:0];
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		kind     = op;
		key      = k;
		do
			@(posedge clk);
		while (in_stall);
		shadow_apply(op, k, fnd, st);
		ans.op  = op;
		ans.k   = k;
		ans.fnd = typed ? want_fnd : fnd;
		ans.st  = typed ? want_st : st;
		pending_answers.push_back(ans);
		if (op != KIND_UNUSED)
			items_sent++;
		@(negedge clk);
	endtask

	// ---------------------------------------------------------------- output side

	// receiver stall: alternating stalled and free stretches, changed at falling edges
	always begin : stall_gen
		int len;
		len = rush ? 0 : idle_len();
		if (len > 0) begin
			out_stall = 1'b1;
			repeat (len) @(negedge clk);
		end
		out_stall = 1'b0;
		len = rush ? 0 : idle_len();
		repeat (1 + len) @(negedge clk);
	end

	task automatic note_mismatch(input string what, input answer_t ans,
			input logic want, input logic got);
		mismatches++;
		if (mismatches <= 10)
			$display("Mismatch at %0t: %s, kind %0d key %h: expected %b, got %b",
				$realtime, what, ans.op, ans.k, want, got);
	endtask

	// each taken result is checked against the oldest answer waiting
	always @(posedge clk) begin : result_check
		answer_t ans;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_answers.size() == 0) begin
				ans = '0;
				note_mismatch("result with nothing expected", ans, 1'b0, 1'b1);
			end else begin
				ans = pending_answers.pop_front();
				if (found !== ans.fnd)
					note_mismatch("found", ans, ans.fnd, found);
				if (status !== ans.st)
					note_mismatch("status", ans, ans.st, status);
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	initial begin : stimulus
		int          episode;
		int          fill;
		int          ops;
		int          r;
		logic [31:0] noise;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			shadow_keys[i] = '0;
			shadow_used[i] = 1'b0;
		end
		arst_n   = 1'b0;
		in_valid = 1'b0;
		kind     = KIND_CLEAR;
		key      = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// opening table: edge keys, every kind, wrap, duplicate, clear
		for (int i = 0; i < $size(opening_ops); i++)
			send_op(opening_ops[i].op, opening_ops[i].k, opening_ops[i].typed,
				opening_ops[i].fnd, opening_ops[i].st);

		// Random episodes: clear, fill, then a mix of lookups and stray operations.
		// The first episode always fills the table and may overfill it, so the
		// full-table cases are reached early; later ones do so now and then.
		episode = 0;
		while (items_sent < TARGET_ITEMS) begin
			rush  = (episode > 0) && ($urandom_range(0, 4) == 0);
			noise = $urandom;
			send_op(KIND_CLEAR, noise[KEY_WIDTH-1:0], 1'b0, 1'b0, 1'b0);
			fill = (episode == 0 || $urandom_range(0, 5) == 0) ?
				$urandom_range(TABLE_SIZE, TABLE_SIZE + 6) : $urandom_range(0, 40);
			for (int i = 0; i < fill; i++)
				send_op(KIND_INSERT, rand_key(), 1'b0, 1'b0, 1'b0);
			ops = $urandom_range(10, 40);
			for (int i = 0; i < ops; i++) begin
				r = $urandom_range(0, 99);
				noise = $urandom;
				if (r < 45)
					send_op(KIND_LOOKUP, present_key(), 1'b0, 1'b0, 1'b0);
				else if (r < 80)
					send_op(KIND_LOOKUP, rand_key(), 1'b0, 1'b0, 1'b0);
				else if (r < 93)
					send_op(KIND_INSERT, rand_key(), 1'b0, 1'b0, 1'b0);
				else if (r < 97)
					send_op(KIND_UNUSED, noise[KEY_WIDTH-1:0], 1'b0, 1'b0, 1'b0);
				else
					send_op(KIND_CLEAR, noise[KEY_WIDTH-1:0], 1'b0, 1'b0, 1'b0);
			end
			episode++;
		end
		in_valid = 1'b0;
		rush     = 1'b0;

		// wait for every answer, then a little longer for anything stray
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_answers.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
